[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the event subscriber table
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define EST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define EST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/est_pkg.sv]
// ----------------------------------------------------------------------------
// est_pkg
// field widths and operation codes of the event subscriber table
// ----------------------------------------------------------------------------
`default_nettype none

package est_pkg;

  localparam int MODE_W    = 3;
  localparam int TYPE_W    = 6;
  localparam int SUB_ID_W  = 8;
  localparam int PAYLOAD_W = 32;
  localparam int COUNT_W   = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUB     = 3'd0,
    MODE_UNSUB   = 3'd1,
    MODE_PUB     = 3'd2,
    MODE_ENABLE  = 3'd3,
    MODE_DISABLE = 3'd4
  } mode_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_REJ = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

[design/est_in_if.sv]
// ----------------------------------------------------------------------------
// est_in_if
// request channel: operation items into the subscriber table
// ----------------------------------------------------------------------------
`default_nettype none

interface est_in_if;
  logic                           valid;
  logic                           ready;
  logic [est_pkg::MODE_W-1:0]     mode;
  logic [est_pkg::TYPE_W-1:0]     event_type;
  logic [est_pkg::SUB_ID_W-1:0]   subscriber_id;
  logic [est_pkg::PAYLOAD_W-1:0]  event_payload;

  modport source (output valid, output mode, output event_type, output subscriber_id,
                  output event_payload, input ready);
  modport sink   (input valid, input mode, input event_type, input subscriber_id,
                  input event_payload, output ready);
endinterface

`default_nettype wire

[design/est_out_if.sv]
// ----------------------------------------------------------------------------
// est_out_if
// result channel: status and delivery items out of the subscriber table
// ----------------------------------------------------------------------------
`default_nettype none

interface est_out_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [est_pkg::SUB_ID_W-1:0]   target_id;
  logic                           target_valid;
  logic [est_pkg::COUNT_W-1:0]    delivery_count;
  logic [est_pkg::PAYLOAD_W-1:0]  payload_out;
  logic                           last;

  modport source (output valid, output status, output target_id, output target_valid,
                  output delivery_count, output payload_out, output last, input ready);
  modport sink   (input valid, input status, input target_id, input target_valid,
                  input delivery_count, input payload_out, input last, output ready);
endinterface

`default_nettype wire

[design/event_subscriber_table_core.sv]
// ----------------------------------------------------------------------------
// event_subscriber_table_core
// per event type ordered subscriber lists with subscribe, unsubscribe,
// publish fan-out and enable or disable with full clear
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | carries
//  ---------+-----+--------------------+-----------------------------------------
//  in_chan  | in  | valid / ready      | mode, event_type, subscriber_id, payload
//  out_chan | out | valid / ready      | status, target, count, payload, last
//
//  cycles: publish reads the list length, then one slot per cycle while the output
//    is not stalled, one result item per slot; subscribe and unsubscribe walk the
//    list one slot per cycle through a single id comparator
//  enable and disable sweep the length memory, then answer
//  reset: synchronous active low, followed by the same sweep of the length
//    memory; in_chan.ready stays low until it is done
//  stalls: one output register; a stalled result holds the sequencer, and a
//    new item is taken while the last result of the previous one still waits
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module event_subscriber_table_core #(
  parameter int NUM_TYPES = 64,
  parameter int SLOTS     = 8,
  parameter int ID_BITS   = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  est_in_if.sink     in_chan,
  est_out_if.source  out_chan
);

  localparam int TYPE_BITS = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEN_BITS  = $clog2(SLOTS + 1);
  localparam int ST_DEPTH  = NUM_TYPES * (1 << SLOT_BITS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LEN, S_SCAN, S_SHIFT, S_PUB, S_RESP
  } state_t;

  // control and item registers
  state_t                              state_r, state_nxt;
  logic                                enabled_r, enabled_nxt;
  logic                                clr_resp_r, clr_resp_nxt;
  logic [TYPE_BITS-1:0]                clr_r, clr_nxt;
  logic [est_pkg::MODE_W-1:0]          mode_r, mode_nxt;
  logic [TYPE_BITS-1:0]                type_r, type_nxt;
  logic [ID_BITS-1:0]                  id_r, id_nxt;
  logic [est_pkg::PAYLOAD_W-1:0]       payload_r, payload_nxt;
  logic [LEN_BITS-1:0]                 n_r, n_nxt;
  logic [SLOT_BITS-1:0]                idx_r, idx_nxt;
  logic                                resp_status_r, resp_status_nxt;
  logic                                resp_pay_r, resp_pay_nxt;

  // output register
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_status_r, out_status_nxt;
  logic [est_pkg::SUB_ID_W-1:0]        out_tid_r, out_tid_nxt;
  logic                                out_tvalid_r, out_tvalid_nxt;
  logic [est_pkg::COUNT_W-1:0]         out_count_r, out_count_nxt;
  logic [est_pkg::PAYLOAD_W-1:0]       out_payload_r, out_payload_nxt;
  logic                                out_last_r, out_last_nxt;

  // memories
  logic                                len_we;
  logic [TYPE_BITS-1:0]                len_waddr;
  logic [LEN_BITS-1:0]                 len_wdata;
  logic [LEN_BITS-1:0]                 len_rdata;
  logic                                st_we;
  logic [TYPE_BITS+SLOT_BITS-1:0]      st_waddr;
  logic [ID_BITS-1:0]                  st_wdata;
  logic [ID_BITS-1:0]                  st_rdata;

  // input decode
  logic [31:0]                         in_type_wide;
  logic                                in_type_ok;
  logic [TYPE_BITS-1:0]                in_type_idx;
  logic [15:0]                         in_id16;
  logic [ID_BITS-1:0]                  in_id;
  logic                                in_fire;

  // shared compare and step unit
  logic                                at_end;
  logic                                hit;
  logic                                emit_ok;
  logic [15:0]                         rd_id16;
  logic [7:0]                          n8;
  logic [est_pkg::COUNT_W-1:0]         n_sat;

  assign in_type_wide = 32'(in_chan.event_type);
  assign in_type_ok   = (in_type_wide != 32'd0) && (in_type_wide < 32'(NUM_TYPES));
  assign in_type_idx  = in_type_wide[TYPE_BITS-1:0];
  assign in_id16      = 16'(in_chan.subscriber_id);
  assign in_id        = in_id16[ID_BITS-1:0];

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  // slot walk: data of slot idx_r sits in st_rdata
  assign at_end  = ((LEN_BITS'(idx_r) + LEN_BITS'(1)) == n_r);
  assign hit     = (st_rdata == id_r);
  assign emit_ok = !out_valid_r || out_chan.ready;
  assign rd_id16 = 16'(st_rdata);
  assign n8      = 8'(n_r);
  assign n_sat   = (n8 > 8'(est_pkg::COUNT_MAX)) ? est_pkg::COUNT_MAX
                                                 : n8[est_pkg::COUNT_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    enabled_nxt     = enabled_r;
    clr_resp_nxt    = clr_resp_r;
    clr_nxt         = clr_r;
    mode_nxt        = mode_r;
    type_nxt        = type_r;
    id_nxt          = id_r;
    payload_nxt     = payload_r;
    n_nxt           = n_r;
    idx_nxt         = idx_r;
    resp_status_nxt = resp_status_r;
    resp_pay_nxt    = resp_pay_r;

    out_valid_nxt   = out_chan.ready ? 1'b0 : out_valid_r;
    out_status_nxt  = out_status_r;
    out_tid_nxt     = out_tid_r;
    out_tvalid_nxt  = out_tvalid_r;
    out_count_nxt   = out_count_r;
    out_payload_nxt = out_payload_r;
    out_last_nxt    = out_last_r;

    len_we    = 1'b0;
    len_waddr = type_r;
    len_wdata = '0;
    st_we     = 1'b0;
    st_waddr  = {type_r, idx_r};
    st_wdata  = id_r;

    unique case (state_r)
      // zero every list length, one type per cycle
      S_CLEAR: begin
        len_we    = 1'b1;
        len_waddr = clr_r;
        len_wdata = '0;
        clr_nxt   = clr_r + TYPE_BITS'(1);
        if (clr_r == TYPE_BITS'(NUM_TYPES - 1)) begin
          if (clr_resp_r) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          mode_nxt     = in_chan.mode;
          type_nxt     = in_type_idx;
          id_nxt       = in_id;
          payload_nxt  = in_chan.event_payload;
          resp_pay_nxt = 1'b0;
          unique case (in_chan.mode) inside
            est_pkg::MODE_SUB, est_pkg::MODE_UNSUB: begin
              if (!in_type_ok || (in_id == '0) || !enabled_r) begin
                resp_status_nxt = est_pkg::STATUS_REJ;
                state_nxt       = S_RESP;
              end else begin
                state_nxt = S_LEN;
              end
            end
            est_pkg::MODE_PUB: begin
              if (!in_type_ok) begin
                resp_status_nxt = est_pkg::STATUS_REJ;
                state_nxt       = S_RESP;
              end else if (!enabled_r) begin
                // nothing subscribed while disabled
                resp_status_nxt = est_pkg::STATUS_OK;
                resp_pay_nxt    = 1'b1;
                state_nxt       = S_RESP;
              end else begin
                state_nxt = S_LEN;
              end
            end
            est_pkg::MODE_ENABLE, est_pkg::MODE_DISABLE: begin
              enabled_nxt     = (in_chan.mode == est_pkg::MODE_ENABLE);
              clr_nxt         = '0;
              clr_resp_nxt    = 1'b1;
              resp_status_nxt = est_pkg::STATUS_OK;
              state_nxt       = S_CLEAR;
            end
            default: begin
              resp_status_nxt = est_pkg::STATUS_REJ;
              state_nxt       = S_RESP;
            end
          endcase
        end
      end

      // length of the addressed list is in len_rdata; slot 0 read issued here
      S_LEN: begin
        n_nxt   = len_rdata;
        idx_nxt = '0;
        unique case (mode_r)
          est_pkg::MODE_SUB: begin
            if (len_rdata >= LEN_BITS'(SLOTS)) begin
              resp_status_nxt = est_pkg::STATUS_REJ;
              state_nxt       = S_RESP;
            end else if (len_rdata == '0) begin
              st_we           = 1'b1;
              st_waddr        = {type_r, SLOT_BITS'(0)};
              len_we          = 1'b1;
              len_wdata       = LEN_BITS'(1);
              resp_status_nxt = est_pkg::STATUS_OK;
              state_nxt       = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          est_pkg::MODE_UNSUB: begin
            if (len_rdata == '0) begin
              resp_status_nxt = est_pkg::STATUS_REJ;
              state_nxt       = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          est_pkg::MODE_PUB: begin
            if (len_rdata == '0) begin
              resp_status_nxt = est_pkg::STATUS_OK;
              resp_pay_nxt    = 1'b1;
              state_nxt       = S_RESP;
            end else begin
              state_nxt = S_PUB;
            end
          end
          default: begin
            resp_status_nxt = est_pkg::STATUS_REJ;
            state_nxt       = S_RESP;
          end
        endcase
      end

      // search for id_r, one slot per cycle
      S_SCAN: begin
        if (mode_r == est_pkg::MODE_SUB) begin
          if (hit) begin
            resp_status_nxt = est_pkg::STATUS_OK;
            state_nxt       = S_RESP;
          end else if (at_end) begin
            // append after the last entry
            st_we           = 1'b1;
            st_waddr        = {type_r, n_r[SLOT_BITS-1:0]};
            len_we          = 1'b1;
            len_wdata       = n_r + LEN_BITS'(1);
            resp_status_nxt = est_pkg::STATUS_OK;
            state_nxt       = S_RESP;
          end else begin
            idx_nxt = idx_r + SLOT_BITS'(1);
          end
        end else begin
          if (hit && at_end) begin
            len_we          = 1'b1;
            len_wdata       = n_r - LEN_BITS'(1);
            resp_status_nxt = est_pkg::STATUS_OK;
            state_nxt       = S_RESP;
          end else if (hit) begin
            idx_nxt   = idx_r + SLOT_BITS'(1);
            state_nxt = S_SHIFT;
          end else if (at_end) begin
            resp_status_nxt = est_pkg::STATUS_REJ;
            state_nxt       = S_RESP;
          end else begin
            idx_nxt = idx_r + SLOT_BITS'(1);
          end
        end
      end

      // move later entries down by one after a removal
      S_SHIFT: begin
        st_we    = 1'b1;
        st_waddr = {type_r, idx_r - SLOT_BITS'(1)};
        st_wdata = st_rdata;
        if (at_end) begin
          len_we          = 1'b1;
          len_wdata       = n_r - LEN_BITS'(1);
          resp_status_nxt = est_pkg::STATUS_OK;
          state_nxt       = S_RESP;
        end else begin
          idx_nxt = idx_r + SLOT_BITS'(1);
        end
      end

      // one delivery item per slot; a stall re-reads the same slot
      S_PUB: begin
        if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = est_pkg::STATUS_OK;
          out_tid_nxt     = rd_id16[est_pkg::SUB_ID_W-1:0];
          out_tvalid_nxt  = 1'b1;
          out_count_nxt   = n_sat;
          out_payload_nxt = payload_r;
          out_last_nxt    = at_end;
          if (at_end) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + SLOT_BITS'(1);
          end
        end
      end

      // single status item
      S_RESP: begin
        if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = resp_status_r;
          out_tid_nxt     = '0;
          out_tvalid_nxt  = 1'b0;
          out_count_nxt   = '0;
          out_payload_nxt = resp_pay_r ? payload_r : '0;
          out_last_nxt    = 1'b1;
          clr_resp_nxt    = 1'b0;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      enabled_r   <= 1'b0;
      clr_resp_r  <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enabled_r   <= enabled_nxt;
      clr_resp_r  <= clr_resp_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r        <= mode_nxt;
    type_r        <= type_nxt;
    id_r          <= id_nxt;
    payload_r     <= payload_nxt;
    n_r           <= n_nxt;
    idx_r         <= idx_nxt;
    resp_status_r <= resp_status_nxt;
    resp_pay_r    <= resp_pay_nxt;
    out_status_r  <= out_status_nxt;
    out_tid_r     <= out_tid_nxt;
    out_tvalid_r  <= out_tvalid_nxt;
    out_count_r   <= out_count_nxt;
    out_payload_r <= out_payload_nxt;
    out_last_r    <= out_last_nxt;
  end

  // list lengths, read at the incoming type while idle
  est_ram #(
    .DEPTH (NUM_TYPES),
    .WIDTH (LEN_BITS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (in_type_idx),
    .rdata (len_rdata)
  );

  // subscriber ids, one row of slots per type
  est_ram #(
    .DEPTH (ST_DEPTH),
    .WIDTH (ID_BITS)
  ) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr ({type_r, idx_nxt}),
    .rdata (st_rdata)
  );

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.target_id      = out_tid_r;
  assign out_chan.target_valid   = out_tvalid_r;
  assign out_chan.delivery_count = out_count_r;
  assign out_chan.payload_out    = out_payload_r;
  assign out_chan.last           = out_last_r;

  // reset always starts the length sweep with nothing on the output
  `EST_ASSERT_ALWAYS(a_rst_sweep, !rst_n |=> (state_r == S_CLEAR) && !out_valid_r,
                     "reset did not start the length sweep")
  // a delivery item is always a successful one with a nonzero count
  `EST_ASSERT(a_delivery_ok, (out_valid_r && out_tvalid_r) |->
              ((out_status_r == est_pkg::STATUS_OK) && (out_count_r != '0)),
              "delivery item with bad status or zero count")
  // an item that is not the last one only comes out of a running publish
  `EST_ASSERT(a_more_follow,
              (out_chan.valid && out_chan.ready && !out_chan.last) |-> (state_r == S_PUB),
              "non-final item taken outside a publish")
  // list lengths change outside a sweep only while the table is enabled
  `EST_ASSERT(a_len_enabled, (len_we && (state_r != S_CLEAR)) |-> enabled_r,
              "list length written while disabled")

endmodule

`default_nettype wire

[design/est_ram.sv]
// ----------------------------------------------------------------------------
// est_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module est_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for event_subscriber_table_core: a scoreboard keeps its
// own copy of the per-type subscriber lists and the enable bit, works out the
// result items of every accepted request and compares each result item,
// field by field, in order. Directed requests hit the corner cases, then
// random traffic runs in three idle patterns with one long output stall.
// ----------------------------------------------------------------------------

module tb_top;
  import est_pkg::*;

  localparam int N_TYPES    = 64;
  localparam int N_SLOTS    = 8;
  localparam int ID_W       = 8;
  localparam int MAX_SHOWN  = 10;
  // longest stretch without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // long output hold-off that backs up the block and stalls its input
  localparam int HOLD_CYCLES = 300;

  // one request item as driven on in_chan
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [TYPE_W-1:0]    etype;
    logic [SUB_ID_W-1:0]  sid;
    logic [PAYLOAD_W-1:0] payload;
  } op_t;

  // one result item as seen on out_chan
  typedef struct packed {
    logic                 status;
    logic [SUB_ID_W-1:0]  tid;
    logic                 tvalid;
    logic [COUNT_W-1:0]   count;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last;
  } res_t;

  // --------------------------------------------------------------------------
  // scoreboard: subscriber list model plus the queue of result items due
  // --------------------------------------------------------------------------
  class fanout_scoreboard;
    logic [SUB_ID_W-1:0] slot_ids [N_TYPES][N_SLOTS];
    int unsigned         list_fill [N_TYPES];
    bit                  table_on;
    res_t                due_q[$];
    int unsigned         mode_seen [8];
    int unsigned         results_seen;
    int unsigned         bad_count;
    int unsigned         widest_fanout;

    function void wipe_lists();
      foreach (list_fill[t]) list_fill[t] = 0;
    endfunction

    // append unless full; an id already listed counts as success
    function logic add_id(int unsigned t, logic [SUB_ID_W-1:0] id);
      int unsigned n;
      n = list_fill[t];
      if (!table_on || n >= N_SLOTS) return STATUS_REJ;
      for (int unsigned i = 0; i < n; i++)
        if (slot_ids[t][i] == id) return STATUS_OK;
      slot_ids[t][n] = id;
      list_fill[t]   = n + 1;
      return STATUS_OK;
    endfunction

    // drop the first match, later entries move down one slot
    function logic drop_id(int unsigned t, logic [SUB_ID_W-1:0] id);
      int unsigned n;
      n = list_fill[t];
      if (!table_on) return STATUS_REJ;
      for (int unsigned i = 0; i < n; i++) begin
        if (slot_ids[t][i] == id) begin
          for (int unsigned j = i; j + 1 < n; j++) slot_ids[t][j] = slot_ids[t][j + 1];
          list_fill[t] = n - 1;
          return STATUS_OK;
        end
      end
      return STATUS_REJ;
    endfunction

    // accepted request: update the lists and queue the result items it causes
    function void note_input(op_t op);
      res_t        r;
      logic        st;
      logic        type_ok;
      int unsigned t;
      int unsigned n;
      r       = '0;
      r.last  = 1'b1;
      st      = STATUS_REJ;
      t       = op.etype;
      type_ok = (t != 0) && (t < N_TYPES);
      mode_seen[op.mode]++;
      case (op.mode)
        MODE_SUB: begin
          if (op.sid != 0 && type_ok) st = add_id(t, op.sid);
        end
        MODE_UNSUB: begin
          if (op.sid != 0 && type_ok) st = drop_id(t, op.sid);
        end
        MODE_PUB: begin
          if (type_ok) begin
            n = table_on ? list_fill[t] : 0;
            r.status  = STATUS_OK;
            r.payload = op.payload;
            if (n == 0) begin
              due_q.push_back(r);
              return;
            end
            if (n > widest_fanout) widest_fanout = n;
            for (int unsigned k = 0; k < n; k++) begin
              r.tid    = slot_ids[t][k];
              r.tvalid = 1'b1;
              r.count  = (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
              r.last   = (k + 1 == n);
              due_q.push_back(r);
            end
            return;
          end
        end
        MODE_ENABLE: begin
          wipe_lists();
          table_on = 1'b1;
          st       = STATUS_OK;
        end
        MODE_DISABLE: begin
          wipe_lists();
          table_on = 1'b0;
          st       = STATUS_OK;
        end
        default: ;
      endcase
      r.status = st;
      due_q.push_back(r);
    endfunction

    // accepted result: compare with the oldest item due
    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (due_q.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_SHOWN)
          $display("unexpected result: status %b id %0d valid %b count %0d payload %h last %b",
                   got.status, got.tid, got.tvalid, got.count, got.payload, got.last);
        return;
      end
      want = due_q.pop_front();
      if (got.status !== want.status || got.tid !== want.tid || got.tvalid !== want.tvalid ||
          got.count !== want.count || got.payload !== want.payload ||
          got.last !== want.last) begin
        bad_count++;
        if (bad_count <= MAX_SHOWN) begin
          $display("result %0d (expected/actual): status %b/%b id %0d/%0d valid %b/%b",
                   results_seen, want.status, got.status, want.tid, got.tid,
                   want.tvalid, got.tvalid);
          $display("  count %0d/%0d payload %h/%h last %b/%b", want.count, got.count,
                   want.payload, got.payload, want.last, got.last);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  est_in_if  in_chan ();
  est_out_if out_chan ();

  event_subscriber_table_core #(
    .NUM_TYPES (N_TYPES),
    .SLOTS     (N_SLOTS),
    .ID_BITS   (ID_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  fanout_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned idle_cycles;

  // random traffic leans on a few hot types and a small id set so lists fill
  logic [TYPE_W-1:0]   hot_types [4];
  logic [SUB_ID_W-1:0] id_pool [12];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // drive every input to a known value before the first edge
  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.mode          <= MODE_PUB;
    in_chan.event_type    <= '0;
    in_chan.subscriber_id <= '0;
    in_chan.event_payload <= '0;
    out_chan.ready        <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // receiver: checks every result item, holds off when told and idles at random
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready)
        sb.check_result('{out_chan.status, out_chan.target_id, out_chan.target_valid,
                          out_chan.delivery_count, out_chan.payload_out, out_chan.last});
      // long hold-off counted here, the sender keeps offering items meanwhile
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d result items still due",
               STALL_LIMIT, sb.due_q.size());
      $display("event_subscriber_table_core: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  function automatic op_t mk_op(logic [MODE_W-1:0] mode, int unsigned t, int unsigned id,
                                logic [PAYLOAD_W-1:0] payload);
    op_t op;
    op.mode    = mode;
    op.etype   = TYPE_W'(t);
    op.sid     = SUB_ID_W'(id);
    op.payload = payload;
    return op;
  endfunction

  // offer one item, with random idle cycles first; valid stays high when
  // the next item follows directly
  task automatic send_op(op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.mode          <= op.mode;
    in_chan.event_type    <= op.etype;
    in_chan.subscriber_id <= op.sid;
    in_chan.event_payload <= op.payload;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_input(op);
  endtask

  task automatic refresh_pools();
    foreach (hot_types[i]) hot_types[i] = TYPE_W'($urandom_range(N_TYPES - 1, 1));
    foreach (id_pool[i])   id_pool[i]   = SUB_ID_W'($urandom_range(255, 1));
  endtask

  // mostly well-formed traffic on hot types, some noise on any type and id
  function automatic op_t random_op();
    op_t         op;
    int unsigned r;
    r          = $urandom_range(99);
    op.payload = $urandom();
    op.etype   = ($urandom_range(9) == 0) ? TYPE_W'($urandom_range(63))
                                          : hot_types[$urandom_range(3)];
    op.sid     = ($urandom_range(19) == 0) ? SUB_ID_W'($urandom_range(255))
                                           : id_pool[$urandom_range(11)];
    // a disabled table rejects nearly everything, so come back soon
    if (!sb.table_on && r < 60) op.mode = MODE_ENABLE;
    else if (r < 2)             op.mode = MODE_DISABLE;
    else if (r < 4)             op.mode = MODE_ENABLE;
    else if (r < 7)             op.mode = MODE_W'($urandom_range(7, 5));
    else if (r < 47)            op.mode = MODE_SUB;
    else if (r < 70)            op.mode = MODE_UNSUB;
    else                        op.mode = MODE_PUB;
    return op;
  endfunction

  task automatic run_random(int unsigned count);
    refresh_pools();
    repeat (count) send_op(random_op());
  endtask

  // corner cases first: disabled table, bad type and id, full list,
  // duplicates, removal from the middle, unknown modes, payload extremes
  task automatic run_directed();
    int unsigned fill_ids [N_SLOTS];
    fill_ids = '{255, 1, 128, 64, 170, 85, 3, 200};
    send_op(mk_op(MODE_PUB,     5, 0, 32'hFFFF_FFFF));   // disabled: no deliveries
    send_op(mk_op(MODE_SUB,     5, 7, 32'h0));           // disabled: rejected
    send_op(mk_op(MODE_UNSUB,   5, 7, 32'h0));
    send_op(mk_op(MODE_ENABLE,  0, 0, 32'h0));
    send_op(mk_op(MODE_SUB,     0, 9, 32'h0));           // type 0 is invalid
    send_op(mk_op(MODE_SUB,    63, 0, 32'h0));           // null id
    send_op(mk_op(MODE_PUB,     0, 0, 32'h1234_5678));   // bad type on publish
    send_op(mk_op(MODE_PUB,    63, 0, 32'h0));           // empty list
    foreach (fill_ids[i]) send_op(mk_op(MODE_SUB, 63, fill_ids[i], 32'h0));
    send_op(mk_op(MODE_SUB,    63, 1, 32'h0));           // full, even though listed
    send_op(mk_op(MODE_SUB,    63, 9, 32'h0));           // full
    send_op(mk_op(MODE_PUB,    63, 0, 32'hA5A5_5A5A));   // full fan-out
    send_op(mk_op(MODE_UNSUB,  63, 64, 32'h0));          // middle removal
    send_op(mk_op(MODE_UNSUB,  63, 64, 32'h0));          // not found
    send_op(mk_op(MODE_SUB,    63, 255, 32'h0));         // duplicate, room left
    send_op(mk_op(MODE_PUB,    63, 0, 32'hFFFF_FFFF));
    for (int unsigned m = 5; m < 8; m++) send_op(mk_op(MODE_W'(m), 63, 255, 32'hFFFF_FFFF));
    send_op(mk_op(MODE_DISABLE, 0, 0, 32'h0));
    send_op(mk_op(MODE_PUB,    63, 0, 32'h0000_0001));   // disabled again
    send_op(mk_op(MODE_ENABLE, 63, 0, 32'h0));
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    send_idle_pct = 23;
    recv_idle_pct = 80;
    hold_left     = 0;
    idle_cycles   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles a little, receiver a lot
    run_directed();
    run_random(110);

    // the other way round
    send_idle_pct = 80;
    recv_idle_pct = 23;
    run_random(135);

    // no idling, but one long hold-off on the output so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = HOLD_CYCLES;
    run_random(135);

    // last item was taken at this edge, stop offering it
    in_chan.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    // room for a late stray result after an enable or disable sweep
    repeat (N_TYPES + 16) @(posedge clk);

    $display("requests: %0d sub, %0d unsub, %0d publish, %0d enable/disable, %0d unknown",
             sb.mode_seen[MODE_SUB], sb.mode_seen[MODE_UNSUB], sb.mode_seen[MODE_PUB],
             sb.mode_seen[MODE_ENABLE] + sb.mode_seen[MODE_DISABLE],
             sb.mode_seen[5] + sb.mode_seen[6] + sb.mode_seen[7]);
    $display("%0d result items compared, widest fan-out %0d, %0d mismatching",
             sb.results_seen, sb.widest_fanout, sb.bad_count);
    if (sb.bad_count == 0 && sb.due_q.size() == 0) begin
      $display("event_subscriber_table_core: match");
    end else begin
      $display("event_subscriber_table_core: mismatch");
    end
    $finish;
  end

endmodule
